FILE: hdl/spm_pkg.sv
// spm_pkg: sizes, codes and the control store of the sv32 page table mapper
// no dependencies; imported by the interfaces and the mapper top level
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

  // pool geometry
  localparam int POOL_PAGES     = 64;
  localparam int VPN_W          = 10;
  localparam int WORDS_PER_PAGE = 1 << VPN_W;
  localparam int SLOT_W         = $clog2(POOL_PAGES);
  localparam int IDX_W          = $clog2(POOL_PAGES + 1);
  localparam int MEM_ADDR_W     = SLOT_W + VPN_W;
  localparam int MEM_DEPTH      = POOL_PAGES * WORDS_PER_PAGE;

  // field widths
  localparam int PAGE_W     = 20;
  localparam int WORD_W     = 32;
  localparam int FLAGS_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int OFS_W      = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'd1;

  // configuration reset values
  localparam logic [PAGE_W-1:0]  POOL_BASE_RST  = '0;
  localparam logic [COUNT_W-1:0] POOL_COUNT_RST = 7'd64;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_UNALIGNED_VIRT = 3'd1,
    ST_UNALIGNED_PHYS = 3'd2,
    ST_NO_MEMORY      = 3'd3,
    ST_OUTSIDE        = 3'd4
  } status_t;

  // sequencer steps (control store addresses)
  typedef enum logic [3:0] {
    STEP_IDLE       = 4'd0,
    STEP_DISPATCH   = 4'd1,
    STEP_TAKE       = 4'd2,
    STEP_CLEAR      = 4'd3,
    STEP_POST       = 4'd4,
    STEP_EMIT       = 4'd5,
    STEP_CHECK      = 4'd6,
    STEP_RD_ROOT    = 4'd7,
    STEP_GET_ENTRY  = 4'd8,
    STEP_LINK       = 4'd9,
    STEP_LEAF_CHECK = 4'd10,
    STEP_LEAF_WR    = 4'd11
  } step_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_TAKE,
    ACT_CLEAR,
    ACT_EMIT,
    ACT_CHECK,
    ACT_RD_ROOT,
    ACT_GET_ENTRY,
    ACT_LINK,
    ACT_LEAF_CHECK,
    ACT_LEAF_WR
  } act_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_XFER,
    C_CMD_MAP,
    C_ERR,
    C_CLR_MORE,
    C_OUT_FREE,
    C_ENTRY_V
  } cond_t;

  // one control word: action, condition, target when true, target when false
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t u;
    begin
      case (s)
        STEP_IDLE:       u = '{ACT_ACCEPT,     C_XFER,     STEP_DISPATCH,   STEP_IDLE};
        STEP_DISPATCH:   u = '{ACT_NOP,        C_CMD_MAP,  STEP_CHECK,      STEP_TAKE};
        STEP_TAKE:       u = '{ACT_TAKE,       C_ERR,      STEP_EMIT,       STEP_CLEAR};
        STEP_CLEAR:      u = '{ACT_CLEAR,      C_CLR_MORE, STEP_CLEAR,      STEP_POST};
        STEP_POST:       u = '{ACT_NOP,        C_CMD_MAP,  STEP_LINK,       STEP_EMIT};
        STEP_EMIT:       u = '{ACT_EMIT,       C_OUT_FREE, STEP_IDLE,       STEP_EMIT};
        STEP_CHECK:      u = '{ACT_CHECK,      C_ERR,      STEP_EMIT,       STEP_RD_ROOT};
        STEP_RD_ROOT:    u = '{ACT_RD_ROOT,    C_ALWAYS,   STEP_GET_ENTRY,  STEP_GET_ENTRY};
        STEP_GET_ENTRY:  u = '{ACT_GET_ENTRY,  C_ENTRY_V,  STEP_LEAF_CHECK, STEP_TAKE};
        STEP_LINK:       u = '{ACT_LINK,       C_ALWAYS,   STEP_LEAF_CHECK, STEP_LEAF_CHECK};
        STEP_LEAF_CHECK: u = '{ACT_LEAF_CHECK, C_ERR,      STEP_EMIT,       STEP_LEAF_WR};
        STEP_LEAF_WR:    u = '{ACT_LEAF_WR,    C_ALWAYS,   STEP_EMIT,       STEP_EMIT};
        default:         u = '{ACT_NOP,        C_ALWAYS,   STEP_IDLE,       STEP_IDLE};
      endcase
      return u;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/spm_in_if.sv
// spm_in_if: command channel of the page table mapper (valid/ready plus payload)
// depends on spm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface spm_in_if;
  import spm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [PAGE_W-1:0]     root_page;
  logic [WORD_W-1:0]     virt_addr;
  logic [WORD_W-1:0]     phys_addr;
  logic [FLAGS_W-1:0]    pte_flags;

  modport source (output valid, command, root_page, virt_addr, phys_addr, pte_flags,
                  input ready);
  modport sink   (input valid, command, root_page, virt_addr, phys_addr, pte_flags,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/spm_out_if.sv
// spm_out_if: result channel of the page table mapper (valid/ready plus payload)
// depends on spm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface spm_out_if;
  import spm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [PAGE_W-1:0]     page_number;
  logic [WORD_W-1:0]     leaf_entry;

  modport source (output valid, status, page_number, leaf_entry, input ready);
  modport sink   (input valid, status, page_number, leaf_entry, output ready);
endinterface

`default_nettype wire

FILE: hdl/spm_ram.sv
// spm_ram: generic single-port ram, one write or read per cycle, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module spm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hdl/sv32_page_table_mapper_unit.sv
// sv32_page_table_mapper_unit: microcoded page pool allocator and sv32 table builder
// allocate takes and clears a pool page; map checks the request, reads the root entry,
// links a new cleared level-0 table if it is invalid, writes the leaf; errors end early
// one item at a time; the page clear through the single ram port dominates
// the next command is taken while a result still waits in the output register
// synchronous active-low reset resets the sequencer, bump index and config; no ram clear
`timescale 1ns / 1ps
`default_nettype none

module sv32_page_table_mapper_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spm_pkg::CFG_DATA_W-1:0]   cfg_data,
  spm_in_if.sink                                in_ch,
  spm_out_if.source                             out_ch
);
  import spm_pkg::*;

  localparam logic [PAGE_W-1:0] POOL_PAGES_P = PAGE_W'(POOL_PAGES);

  // sequencer and control registers
  step_t              step_r, step_nxt;
  logic [IDX_W-1:0]   next_free_r, next_free_nxt;
  logic [PAGE_W-1:0]  base_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r, out_valid_nxt;

  // datapath registers
  logic                cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]   root_r, root_nxt;
  logic [WORD_W-1:0]   va_r, va_nxt;
  logic [WORD_W-1:0]   pa_r, pa_nxt;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt;
  status_t             status_r, status_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [WORD_W-1:0]   leaf_r, leaf_nxt;
  logic [WORD_W-1:0]   entry_r, entry_nxt;
  logic [SLOT_W-1:0]   rslot_r, rslot_nxt;
  logic [SLOT_W-1:0]   tslot_r, tslot_nxt;
  logic [SLOT_W-1:0]   clr_slot_r, clr_slot_nxt;
  logic [VPN_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;
  logic [WORD_W-1:0]   out_leaf_r, out_leaf_nxt;

  // ram port
  logic                  ram_we;
  logic [MEM_ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;

  // shared helpers
  ucode_t            uc;
  logic [PAGE_W-1:0] usable;
  logic [PAGE_W-1:0] root_off;
  logic [PAGE_W-1:0] tbl_off;
  logic              in_xfer;
  logic              out_free;
  logic              cond_hit;

  spm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // pool size in effect and slot offsets
  assign usable   = (PAGE_W'(count_r) < POOL_PAGES_P) ? PAGE_W'(count_r) : POOL_PAGES_P;
  assign root_off = root_r - base_r;
  assign tbl_off  = entry_r[WORD_W-3:VPN_W] - base_r;

  assign uc       = ucode_rom(step_r);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // channel drive, no input transfer while in reset
  assign in_ch.ready        = rst_n && (uc.act == ACT_ACCEPT);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.page_number = out_page_r;
  assign out_ch.leaf_entry  = out_leaf_r;

  // control word decode: datapath actions and branch
  always_comb begin
    step_nxt       = step_r;
    next_free_nxt  = next_free_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cmd_nxt        = cmd_r;
    root_nxt       = root_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    flags_nxt      = flags_r;
    status_nxt     = status_r;
    page_nxt       = page_r;
    leaf_nxt       = leaf_r;
    entry_nxt      = entry_r;
    rslot_nxt      = rslot_r;
    tslot_nxt      = tslot_r;
    clr_slot_nxt   = clr_slot_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_leaf_nxt   = out_leaf_r;
    ram_we         = 1'b0;
    ram_addr       = {rslot_r, va_r[WORD_W-1:WORD_W-VPN_W]};
    ram_wdata      = '0;

    case (uc.act)
      ACT_ACCEPT: begin
        if (in_xfer) begin
          cmd_nxt    = in_ch.command;
          root_nxt   = in_ch.root_page;
          va_nxt     = in_ch.virt_addr;
          pa_nxt     = in_ch.phys_addr;
          flags_nxt  = in_ch.pte_flags;
          status_nxt = ST_OK;
          page_nxt   = '0;
          leaf_nxt   = '0;
        end
      end
      ACT_TAKE: begin
        if (PAGE_W'(next_free_r) >= usable) begin
          status_nxt = ST_NO_MEMORY;
        end else begin
          page_nxt      = base_r + PAGE_W'(next_free_r);
          clr_slot_nxt  = next_free_r[SLOT_W-1:0];
          clr_cnt_nxt   = '0;
          next_free_nxt = next_free_r + IDX_W'(1);
        end
      end
      ACT_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = {clr_slot_r, clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + VPN_W'(1);
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_page_nxt   = (status_r == ST_OK) ? page_r : '0;
          out_leaf_nxt   = (status_r == ST_OK) ? leaf_r : '0;
        end
      end
      ACT_CHECK: begin
        rslot_nxt = root_off[SLOT_W-1:0];
        if (va_r[OFS_W-1:0] != '0) begin
          status_nxt = ST_UNALIGNED_VIRT;
        end else if (pa_r[OFS_W-1:0] != '0) begin
          status_nxt = ST_UNALIGNED_PHYS;
        end else if (root_off >= usable) begin
          status_nxt = ST_OUTSIDE;
        end
      end
      ACT_RD_ROOT: begin
        ram_addr = {rslot_r, va_r[WORD_W-1:WORD_W-VPN_W]};
      end
      ACT_GET_ENTRY: begin
        entry_nxt = ram_rdata;
      end
      ACT_LINK: begin
        ram_we    = 1'b1;
        ram_addr  = {rslot_r, va_r[WORD_W-1:WORD_W-VPN_W]};
        ram_wdata = {2'b00, page_r, {(VPN_W-1){1'b0}}, 1'b1};
        entry_nxt = {2'b00, page_r, {(VPN_W-1){1'b0}}, 1'b1};
      end
      ACT_LEAF_CHECK: begin
        tslot_nxt = tbl_off[SLOT_W-1:0];
        if (entry_r[WORD_W-1:WORD_W-2] != 2'b00 || tbl_off >= usable) begin
          status_nxt = ST_OUTSIDE;
        end
      end
      ACT_LEAF_WR: begin
        ram_we    = 1'b1;
        ram_addr  = {tslot_r, va_r[WORD_W-VPN_W-1:OFS_W]};
        ram_wdata = {2'b00, pa_r[WORD_W-1:OFS_W], 2'b00, flags_r[FLAGS_W-1:1], 1'b1};
        leaf_nxt  = {2'b00, pa_r[WORD_W-1:OFS_W], 2'b00, flags_r[FLAGS_W-1:1], 1'b1};
      end
      default: begin
      end
    endcase

    // branch condition
    case (uc.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_XFER:     cond_hit = in_xfer;
      C_CMD_MAP:  cond_hit = (cmd_r == CMD_MAP);
      C_ERR:      cond_hit = (status_nxt != ST_OK);
      C_CLR_MORE: cond_hit = (clr_cnt_r != {VPN_W{1'b1}});
      C_OUT_FREE: cond_hit = out_free;
      C_ENTRY_V:  cond_hit = ram_rdata[0];
      default:    cond_hit = 1'b0;
    endcase
    step_nxt = cond_hit ? uc.tgt_t : uc.tgt_f;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
      base_r      <= POOL_BASE_RST;
      count_r     <= POOL_COUNT_RST;
    end else begin
      step_r      <= step_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_POOL_BASE) begin
        base_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_POOL_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    root_r       <= root_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    flags_r      <= flags_nxt;
    status_r     <= status_nxt;
    page_r       <= page_nxt;
    leaf_r       <= leaf_nxt;
    entry_r      <= entry_nxt;
    rslot_r      <= rslot_nxt;
    tslot_r      <= tslot_nxt;
    clr_slot_r   <= clr_slot_nxt;
    clr_cnt_r    <= clr_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_leaf_r   <= out_leaf_nxt;
  end

  // bump index never passes the built pool
  a_next_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PAGE_W'(next_free_r) <= POOL_PAGES_P)
    else $error("bump index beyond pool");

  // bump index only steps by one page
  a_next_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && next_free_r != $past(next_free_r) |->
      next_free_r == $past(next_free_r) + IDX_W'(1))
    else $error("bump index jumped");

  // no ram write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_IDLE |-> !ram_we)
    else $error("ram written while idle");

  // failed commands report no page and no leaf
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_page_r == '0 && out_leaf_r == '0)
    else $error("error result carries data");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for the sv32 page table mapper unit
// depends on spm_pkg, spm_in_if, spm_out_if and sv32_page_table_mapper_unit
`timescale 1ns / 1ps

module testbench;
  import spm_pkg::*;

  // longest quiet stretch of a correct run is a page clear plus a long receiver
  // hold-off; allow several times that
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic                command;
    logic [PAGE_W-1:0]   root_page;
    logic [WORD_W-1:0]   virt_addr;
    logic [WORD_W-1:0]   phys_addr;
    logic [FLAGS_W-1:0]  pte_flags;
  } pool_cmd_t;

  typedef struct {
    status_t             status;
    logic [PAGE_W-1:0]   page_number;
    logic [WORD_W-1:0]   leaf_entry;
  } pool_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spm_in_if  in_ch ();
  spm_out_if out_ch ();

  sv32_page_table_mapper_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // mirror of the mapper: registers, bump index and pool contents
  logic [PAGE_W-1:0]  mirror_base;
  logic [COUNT_W-1:0] mirror_count;
  int unsigned        free_idx;
  logic [WORD_W-1:0]  pool_words [MEM_DEPTH];

  pool_reply_t pool_replies [$];
  pool_reply_t head_reply;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int fail_count;
  int sent_count;
  int reply_count;
  int status_tally [5];
  logic [VPN_W-1:0] hot_vpn1 [8];

  always #5 clk = ~clk;

  // number of pool pages in effect
  function automatic int unsigned usable_pages();
    return (int'(mirror_count) < POOL_PAGES) ? int'(mirror_count) : POOL_PAGES;
  endfunction

  // pool slot of a page number (22 bits wide to catch entries above 2^20)
  function automatic bit pool_slot(input logic [21:0] page, output int unsigned slot);
    logic [PAGE_W-1:0] off;
    off  = page[PAGE_W-1:0] - mirror_base;
    slot = int'(off);
    return (page[21:20] == 2'b00) && (off < usable_pages());
  endfunction

  // bump allocation with page clear
  function automatic bit take_pool_page(output logic [PAGE_W-1:0] page);
    if (free_idx >= usable_pages())
      return 1'b0;
    for (int w = 0; w < WORDS_PER_PAGE; w++)
      pool_words[free_idx * WORDS_PER_PAGE + w] = '0;
    page = mirror_base + PAGE_W'(free_idx);
    free_idx++;
    return 1'b1;
  endfunction

  // effect of one command on the pool, and the reply it produces
  function automatic pool_reply_t run_pool_command(input pool_cmd_t c);
    pool_reply_t       r;
    logic [PAGE_W-1:0] new_page;
    int unsigned       rslot;
    int unsigned       tslot;
    logic [WORD_W-1:0] entry;
    r.status      = ST_OK;
    r.page_number = '0;
    r.leaf_entry  = '0;
    if (c.command == CMD_ALLOC) begin
      if (take_pool_page(new_page))
        r.page_number = new_page;
      else
        r.status = ST_NO_MEMORY;
      return r;
    end
    if (c.virt_addr[OFS_W-1:0] != '0)
      r.status = ST_UNALIGNED_VIRT;
    else if (c.phys_addr[OFS_W-1:0] != '0)
      r.status = ST_UNALIGNED_PHYS;
    else if (!pool_slot({2'b00, c.root_page}, rslot))
      r.status = ST_OUTSIDE;
    else begin
      entry = pool_words[rslot * WORDS_PER_PAGE + c.virt_addr[31:22]];
      // missing level-0 table: allocate and link it
      if (!entry[0]) begin
        if (take_pool_page(new_page)) begin
          entry = {2'b00, new_page, 10'd1};
          pool_words[rslot * WORDS_PER_PAGE + c.virt_addr[31:22]] = entry;
          r.page_number = new_page;
        end else begin
          r.status = ST_NO_MEMORY;
        end
      end
      if (r.status == ST_OK) begin
        if (!pool_slot(entry[31:10], tslot)) begin
          r.status = ST_OUTSIDE;
        end else begin
          r.leaf_entry = {2'b00, c.phys_addr[31:12], 2'b00, c.pte_flags} | 32'd1;
          pool_words[tslot * WORDS_PER_PAGE + c.virt_addr[21:12]] = r.leaf_entry;
        end
      end
    end
    if (r.status != ST_OK) begin
      r.page_number = '0;
      r.leaf_entry  = '0;
    end
    return r;
  endfunction

  // root page that never leads to a read of a page not yet cleared
  function automatic logic [PAGE_W-1:0] pick_root(input bit from_taken);
    int unsigned       u;
    int unsigned       n;
    logic [PAGE_W-1:0] cand;
    logic [PAGE_W-1:0] off;
    u = usable_pages();
    n = (free_idx < u) ? free_idx : u;
    if (from_taken && n > 0) begin
      cand = mirror_base + PAGE_W'($urandom_range(0, n - 1));
      return cand;
    end
    cand = PAGE_W'($urandom);
    off  = cand - mirror_base;
    if (off < u && off >= free_idx)
      cand = mirror_base + PAGE_W'(u);
    return cand;
  endfunction

  // one command transfer on the input channel, then its prediction
  task automatic issue_command(input pool_cmd_t c);
    pool_reply_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c.command;
    in_ch.root_page <= c.root_page;
    in_ch.virt_addr <= c.virt_addr;
    in_ch.phys_addr <= c.phys_addr;
    in_ch.pte_flags <= c.pte_flags;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = run_pool_command(c);
    pool_replies.push_back(r);
    status_tally[int'(r.status)]++;
    sent_count++;
  endtask

  task automatic send_map(input logic [PAGE_W-1:0] root, input logic [WORD_W-1:0] va,
                          input logic [WORD_W-1:0] pa, input logic [FLAGS_W-1:0] flags);
    pool_cmd_t c;
    c.command   = CMD_MAP;
    c.root_page = root;
    c.virt_addr = va;
    c.phys_addr = pa;
    c.pte_flags = flags;
    issue_command(c);
  endtask

  // allocate with random content in the unused fields
  task automatic send_alloc();
    pool_cmd_t c;
    c.command   = CMD_ALLOC;
    c.root_page = PAGE_W'($urandom);
    c.virt_addr = $urandom;
    c.phys_addr = $urandom;
    c.pte_flags = FLAGS_W'($urandom);
    issue_command(c);
  endtask

  // stop offering and wait until every predicted reply has been seen
  task automatic await_replies();
    in_ch.valid <= 1'b0;
    while (pool_replies.size() != 0) @(posedge clk);
  endtask

  // write both registers; only called with the block idle
  task automatic program_pool(input logic [PAGE_W-1:0] base, input logic [COUNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POOL_BASE;
    cfg_data  <= base;
    @(posedge clk);
    mirror_base = base;
    cfg_index <= CFG_POOL_COUNT;
    cfg_data  <= {{(CFG_DATA_W - COUNT_W){1'b0}}, count};
    @(posedge clk);
    mirror_count = count;
    cfg_we <= 1'b0;
  endtask

  task automatic test_alignment_and_outside();
    // root outside the pool, then the alignment checks and their order
    send_map(20'h80000, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_map(20'h80000, 32'h0000_0FFF, 32'h0000_0000, 8'h01);
    send_map(20'h80000, 32'h0000_0001, 32'h0000_0001, 8'hFF);
    send_map(20'h80000, 32'h0000_1000, 32'hFFFF_FFFF, 8'h55);
  endtask

  task automatic test_alloc_and_link();
    // root table, new level-0 tables, reuse of a linked table
    send_alloc();
    send_map(20'h00000, 32'hFFFF_F000, 32'hFFFF_F000, 8'hFF);
    send_map(20'h00000, 32'hFFFF_E000, 32'h0000_0000, 8'h00);
    send_map(20'h00000, 32'h0000_0000, 32'h1234_5000, 8'hAA);
    send_alloc();
    send_map(20'h00003, 32'h0040_0000, 32'h8000_0000, 8'h0E);
  endtask

  task automatic test_pool_limits();
    // pool used up: allocate and map that needs a table both run out
    await_replies();
    program_pool(20'h00000, 7'd5);
    send_alloc();
    send_map(20'h00000, 32'h0080_0000, 32'h0000_2000, 8'h0F);
    send_map(20'h00000, 32'h0000_1000, 32'h0000_3000, 8'h0F);
    // empty pool: every page is outside
    await_replies();
    program_pool(20'h00000, 7'd0);
    send_alloc();
    send_map(20'h00000, 32'h0000_1000, 32'h0000_3000, 8'h0F);
    // valid root entry that points past the pool
    await_replies();
    program_pool(20'h00000, 7'd1);
    send_map(20'h00000, 32'hFFC0_0000, 32'h0000_4000, 8'h03);
  endtask

  task automatic test_base_wrap();
    // pool straddles the top of the page number space
    await_replies();
    program_pool(20'hFFFFE, 7'd64);
    send_alloc();
    send_map(20'hFFFFE, 32'hFFFF_F000, 32'hABCD_E000, 8'hC7);
    send_map(20'hFFFFF, 32'h00C0_0000, 32'h0000_5000, 8'h1F);
    send_alloc();
  endtask

  // mostly well-formed map bursts into taken roots, plus allocs and noise
  task automatic test_random_mapping(input int n_items, input int s_pct, input int r_pct,
                                     input logic [PAGE_W-1:0] base,
                                     input logic [COUNT_W-1:0] count);
    int                roll;
    int                burst;
    int                done;
    logic [PAGE_W-1:0] root;
    logic [VPN_W-1:0]  vpn1;
    logic [WORD_W-1:0] va;
    logic [WORD_W-1:0] pa;
    await_replies();
    program_pool(base, count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    hot_vpn1[0] = '0;
    hot_vpn1[1] = '1;
    for (int k = 2; k < 8; k++)
      hot_vpn1[k] = VPN_W'($urandom);
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_alloc();
        done++;
      end else if (roll < 20) begin
        // noise: mostly unaligned addresses, any safe root
        va = $urandom;
        pa = $urandom;
        if ($urandom_range(0, 1) == 0)
          va[OFS_W-1:0] = '0;
        if ($urandom_range(0, 3) == 0)
          pa[OFS_W-1:0] = '0;
        send_map(pick_root(1'($urandom_range(0, 1))), va, pa, FLAGS_W'($urandom));
        done++;
      end else begin
        root  = pick_root(1'b1);
        vpn1  = hot_vpn1[$urandom_range(0, 7)];
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst; b++) begin
          va = {vpn1, 10'($urandom), 12'h000};
          pa = {20'($urandom), 12'h000};
          send_map(root, va, pa, FLAGS_W'($urandom));
          done++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    pool_cmd_t c;
    await_replies();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 400;
    // keep offering while the result side is held off
    for (int i = 0; i < 40; i++) begin
      c.command   = CMD_MAP;
      c.root_page = pick_root(1'b1);
      c.virt_addr = {hot_vpn1[i % 8], 10'($urandom), 12'h000};
      c.phys_addr = {20'($urandom), 12'h000};
      c.pte_flags = FLAGS_W'($urandom);
      issue_command(c);
    end
  endtask

  // result side ready, with random stalls and requested hold-offs
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reply_count++;
      if (pool_replies.size() == 0) begin
        $display("%0t: unexpected reply, status %0d page %h leaf %h", $time,
                 out_ch.status, out_ch.page_number, out_ch.leaf_entry);
        fail_count++;
      end else begin
        head_reply = pool_replies.pop_front();
        if (out_ch.status !== head_reply.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time,
                   head_reply.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.page_number !== head_reply.page_number) begin
          $display("%0t: page_number mismatch, expected %h, got %h", $time,
                   head_reply.page_number, out_ch.page_number);
          fail_count++;
        end
        if (out_ch.leaf_entry !== head_reply.leaf_entry) begin
          $display("%0t: leaf_entry mismatch, expected %h, got %h", $time,
                   head_reply.leaf_entry, out_ch.leaf_entry);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d replies outstanding", $time,
             STALL_LIMIT, pool_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    // known values on every input from time zero
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_POOL_BASE;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_ALLOC;
    in_ch.root_page <= '0;
    in_ch.virt_addr <= '0;
    in_ch.phys_addr <= '0;
    in_ch.pte_flags <= '0;
    mirror_base  = POOL_BASE_RST;
    mirror_count = POOL_COUNT_RST;
    free_idx     = 0;
    foreach (pool_words[w]) pool_words[w] = '0;
    foreach (status_tally[s]) status_tally[s] = 0;
    foreach (hot_vpn1[k]) hot_vpn1[k] = '0;
    fail_count    = 0;
    sent_count    = 0;
    reply_count   = 0;
    hold_request  = 0;
    send_idle_pct = 9;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alignment_and_outside();
    test_alloc_and_link();
    test_pool_limits();
    test_base_wrap();
    test_random_mapping(310, 9, 47, 20'h00000, 7'd64);
    test_random_mapping(310, 9, 47, 20'($urandom), 7'($urandom_range(1, 64)));
    test_random_mapping(310, 47, 9, 20'hFFFFF, 7'd1);
    test_random_mapping(310, 47, 9, 20'h00000, 7'd32);
    test_random_mapping(300, 0, 0, 20'h00000, 7'd64);
    test_output_backpressure();
    test_random_mapping(300, 0, 0, 20'($urandom), 7'd64);

    await_replies();
    repeat (50) @(posedge clk);

    $display("ran %0d commands, checked %0d replies, %0d pool pages taken", sent_count,
             reply_count, free_idx);
    $display("replies: ok %0d, bad virt %0d, bad phys %0d, no memory %0d, outside %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (fail_count == 0 && pool_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
